[rtl/core/spq_pkg.sv]
// Shared types and constants for the stable priority queue core.
// Depends on nothing; imported by every module of the core but spq_ram.
package spq_pkg;

	// Field widths of the stream items
	localparam int PRIO_W    = 3;
	localparam int EXT_PAY_W = 32;
	localparam int OCC_W     = 5;

	// Packed widths of the stream ports
	localparam int S_TDATA_W = 40;
	localparam int S_TUSER_W = 1;
	localparam int M_TDATA_W = 48;

	// Operation codes carried in s_tuser
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_FULL  = 2'd1,
		STATUS_EMPTY = 2'd2
	} status_t;

	// One result item before packing
	typedef struct packed {
		logic [OCC_W-1:0]     occ;
		logic [PRIO_W-1:0]    prio;
		logic [EXT_PAY_W-1:0] payload;
		status_t              status;
	} res_t;

endpackage

[rtl/core/spq_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module spq_ram #(
	parameter int WIDTH = 35,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/core/spq_out.sv]
// Output register of the queue: holds one result item until the sink takes it.
// Depends on spq_pkg.
module spq_out import spq_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  res_t                 res,
	output logic                 room,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// fields from bit 0: status[1:0], out_payload[33:2], out_priority[36:34],
	// occupancy[41:37], zero fill[47:42]
	output logic [M_TDATA_W-1:0] m_tdata
);

	logic vld_q;
	res_t data_q;

	assign room = !vld_q || m_tready;

	// Valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (load) begin
			vld_q <= 1'b1;
		end else if (m_tready) begin
			vld_q <= 1'b0;
		end
	end

	// Payload of the held item
	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= res;
		end
	end

	assign m_tvalid = vld_q;
	assign m_tdata  = {(M_TDATA_W - $bits(res_t))'(0), data_q};

endmodule

[rtl/core/spq_ctrl.sv]
// Queue sequencer: slot RAM, fill count, winner scan and gap-closing shift.
// Depends on spq_pkg and spq_ram.
module spq_ctrl import spq_pkg::*; #(
	parameter int DEPTH        = 16,
	parameter int PAYLOAD_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,
	input  logic [S_TUSER_W-1:0] s_tuser,
	input  logic                 room,
	output logic                 load,
	output res_t                 res
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int EW = PAYLOAD_BITS + PRIO_W;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_SHIFT = 4'b0100,
		ST_FIN   = 4'b1000
	} state_t;

	state_t                  state_q;
	logic [CW-1:0]           fill_q;
	logic [AW-1:0]           last_q;
	logic [AW-1:0]           rd_idx_q;
	logic                    more_q;
	logic                    rd_vld_s1;
	logic [AW-1:0]           rd_idx_s1;
	logic [PRIO_W-1:0]       best_prio_q;
	logic [PAYLOAD_BITS-1:0] best_pay_q;
	logic [AW-1:0]           best_idx_q;

	logic                    ram_we;
	logic [AW-1:0]           ram_waddr;
	logic [EW-1:0]           ram_wdata;
	logic                    ram_re;
	logic [AW-1:0]           ram_raddr;
	logic [EW-1:0]           ram_rdata;

	logic                    in_mode;
	logic [PRIO_W-1:0]       in_prio;
	logic [PAYLOAD_BITS-1:0] in_pay;
	logic                    accept;
	logic                    full;
	logic                    empty;
	logic                    start_rm;
	logic                    ins_wr;
	logic                    shift_wr;
	logic                    issue;
	logic [PRIO_W-1:0]       rd_prio;
	logic [PAYLOAD_BITS-1:0] rd_pay;
	logic                    take;
	logic [AW-1:0]           win_idx;
	logic                    scan_end;
	logic                    shift_end;
	logic                    fin_go;

	// Slot store: {priority, payload} per slot, arrival order from slot 0
	spq_ram #(
		.WIDTH(EW),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Input unpacking
	assign in_mode = s_tuser[0];
	assign in_prio = s_tdata[PRIO_W-1:0];
	assign in_pay  = PAYLOAD_BITS'(s_tdata[PRIO_W +: EXT_PAY_W]);

	assign s_tready = (state_q == ST_IDLE) && room;
	assign accept   = s_tvalid && s_tready;
	assign full     = (fill_q == CW'(DEPTH));
	assign empty    = (fill_q == '0);
	assign start_rm = accept && (in_mode == OP_REMOVE) && !empty;
	assign ins_wr   = accept && (in_mode == OP_INSERT) && !full;

	// Read side: one slot per cycle during scan and shift
	assign issue     = ((state_q == ST_SCAN) || (state_q == ST_SHIFT)) && more_q;
	assign ram_re    = start_rm || issue;
	assign ram_raddr = start_rm ? '0 : rd_idx_q;

	assign rd_prio = ram_rdata[EW-1 -: PRIO_W];
	assign rd_pay  = ram_rdata[PAYLOAD_BITS-1:0];

	// Winner compare: strictly higher priority replaces, so ties keep the earlier slot
	assign take      = (rd_idx_s1 == '0) || (rd_prio > best_prio_q);
	assign win_idx   = take ? rd_idx_s1 : best_idx_q;
	assign scan_end  = (state_q == ST_SCAN) && rd_vld_s1 && (rd_idx_s1 == last_q);
	assign shift_end = (state_q == ST_SHIFT) && rd_vld_s1 && (rd_idx_s1 == last_q);
	assign fin_go    = (state_q == ST_FIN) && room;

	// Write side: insert at the first free slot, or move slot k+1 down to k
	assign shift_wr  = (state_q == ST_SHIFT) && rd_vld_s1;
	assign ram_we    = ins_wr || shift_wr;
	assign ram_waddr = ins_wr ? fill_q[AW-1:0] : (rd_idx_s1 - 1'b1);
	assign ram_wdata = ins_wr ? {in_prio, in_pay} : ram_rdata;

	// Result item
	always_comb begin
		load = 1'b0;
		res  = '{occ: '0, prio: '0, payload: '0, status: STATUS_OK};
		if (accept) begin
			if (in_mode == OP_INSERT) begin
				load = 1'b1;
				if (full) begin
					res.status = STATUS_FULL;
					res.occ    = OCC_W'(fill_q);
				end else begin
					res.occ = OCC_W'(fill_q + 1'b1);
				end
			end else if (empty) begin
				load       = 1'b1;
				res.status = STATUS_EMPTY;
			end
		end else if (fin_go) begin
			load        = 1'b1;
			res.payload = EXT_PAY_W'(best_pay_q);
			res.prio    = best_prio_q;
			res.occ     = OCC_W'(fill_q - 1'b1);
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start_rm) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_end) begin
						state_q <= (win_idx == last_q) ? ST_FIN : ST_SHIFT;
					end
				end
				ST_SHIFT: begin
					if (shift_end) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (room) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (ins_wr) begin
			fill_q <= fill_q + 1'b1;
		end else if (fin_go) begin
			fill_q <= fill_q - 1'b1;
		end
	end

	// Read address walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			more_q    <= 1'b0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= ram_re;
			if (start_rm) begin
				more_q <= (fill_q != CW'(1));
			end else if (issue) begin
				more_q <= (rd_idx_q != last_q);
			end else if (scan_end) begin
				more_q <= (win_idx != last_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= ram_raddr;
		if (start_rm) begin
			rd_idx_q <= AW'(1);
			last_q   <= AW'(fill_q - 1'b1);
		end else if (issue) begin
			rd_idx_q <= rd_idx_q + 1'b1;
		end else if (scan_end) begin
			rd_idx_q <= win_idx + 1'b1;
		end
	end

	// Best entry so far
	always_ff @(posedge clk) begin
		if ((state_q == ST_SCAN) && rd_vld_s1 && take) begin
			best_prio_q <= rd_prio;
			best_pay_q  <= rd_pay;
			best_idx_q  <= rd_idx_s1;
		end
	end

endmodule

[rtl/core/stable_priority_queue_core.sv]
// Stable priority queue core. An insert or a reject, and a remove on an empty queue,
// give their result item in the cycle after acceptance; a new item is taken once the
// output register has room. A remove first reads every entry to scan for the winner, then
// reads each later slot and moves it down by one, unless the winner is the last entry.
// Reset clears the fill count, sequencer and output valid at once; slot RAM is not cleared.
// Depends on spq_pkg, spq_ctrl and spq_out.
module stable_priority_queue_core import spq_pkg::*; #(
	parameter int DEPTH        = 16,
	parameter int PAYLOAD_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// fields from bit 0: priority_req[2:0], payload[34:3], zero fill[39:35]
	input  logic [S_TDATA_W-1:0] s_tdata,
	// fields from bit 0: mode[0]
	input  logic [S_TUSER_W-1:0] s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// fields from bit 0: status[1:0], out_payload[33:2], out_priority[36:34],
	// occupancy[41:37], zero fill[47:42]
	output logic [M_TDATA_W-1:0] m_tdata
);

	logic room;
	logic load;
	res_t res;

	spq_ctrl #(
		.DEPTH       (DEPTH),
		.PAYLOAD_BITS(PAYLOAD_BITS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.room    (room),
		.load    (load),
		.res     (res)
	);

	spq_out u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (load),
		.res     (res),
		.room    (room),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

endmodule

[rtl/core/spq_chk.sv]
// Port-level checks on the queue core's result stream, bound to the top level.
// Depends on spq_pkg and stable_priority_queue_core.
module spq_chk import spq_pkg::*; #(
	parameter int DEPTH = 16
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata
);

	logic [1:0]       st;
	logic [OCC_W-1:0] occ;

	assign st  = m_tdata[1:0];
	assign occ = m_tdata[41:37];

	// A stalled item holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result item changed while stalled");

	// Rejected insert or empty remove carries no entry
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (st != STATUS_OK) |-> (m_tdata[36:2] == '0))
		else $error("failed item carries entry data");

	// A full reject reports a full queue
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (st == STATUS_FULL) |-> (occ == OCC_W'(DEPTH)))
		else $error("full reject with wrong occupancy");

	// An empty remove reports an empty queue
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (st == STATUS_EMPTY) |-> (occ == '0))
		else $error("empty remove with nonzero occupancy");

endmodule

bind stable_priority_queue_core spq_chk #(.DEPTH(DEPTH)) u_chk (.*);

[dv/tb_stable_priority_queue_core.sv]
// Self-checking testbench for stable_priority_queue_core: mirrors the queue in a small
// class, drives insert and remove items with random gaps, checks every result item.
// Depends on spq_pkg and the stable_priority_queue_core RTL.
`timescale 1ns / 1ps

module tb_stable_priority_queue_core;
	import spq_pkg::*;

	localparam int QDEPTH     = 16;
	localparam int STALL_MAX  = 4000;
	localparam int HOLD_LEN   = 400;
	localparam int HOLD_AT    = 200;
	localparam int RAND_ITEMS = 1300;
	localparam int SEG_LEN    = 100;
	localparam int TAIL_WAIT  = 80;

	// Mirror of the queue contents and the results it must produce
	class pq_mirror;
		logic [PRIO_W-1:0]    held_prio [QDEPTH];
		logic [EXT_PAY_W-1:0] held_pay [QDEPTH];
		int                   held_count;
		res_t                 expected_results [$];
		int                   errors;

		function new();
			held_count = 0;
			errors     = 0;
		endfunction

		// Work out the result of one accepted request and queue it
		function void note_request(logic mode, logic [PRIO_W-1:0] prio,
				logic [EXT_PAY_W-1:0] pay);
			res_t r;
			int   best;
			r = '0;
			r.status = STATUS_OK;
			if (mode == OP_INSERT) begin
				if (held_count >= QDEPTH) begin
					r.status = STATUS_FULL;
				end else begin
					held_prio[held_count] = prio;
					held_pay[held_count]  = pay;
					held_count++;
				end
			end else if (held_count == 0) begin
				r.status = STATUS_EMPTY;
			end else begin
				// highest priority wins, earliest slot among equals
				best = 0;
				for (int k = 1; k < held_count; k++)
					if (held_prio[k] > held_prio[best])
						best = k;
				r.payload = held_pay[best];
				r.prio    = held_prio[best];
				for (int k = best; k + 1 < held_count; k++) begin
					held_prio[k] = held_prio[k + 1];
					held_pay[k]  = held_pay[k + 1];
				end
				held_count--;
			end
			r.occ = 5'(held_count);
			expected_results.insert(expected_results.size(), r);
		endfunction

		// Compare one accepted result item with the oldest expectation
		function void check_response(logic [M_TDATA_W-1:0] word);
			res_t exp_r;
			res_t got;
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result item %0h", $realtime, word);
				errors++;
				return;
			end
			exp_r = expected_results.pop_front();
			got   = res_t'(word[$bits(res_t)-1:0]);
			if (got.status !== exp_r.status) begin
				$display("%0t: status expected %0d actual %0d",
					$realtime, exp_r.status, got.status);
				errors++;
			end
			if (got.payload !== exp_r.payload) begin
				$display("%0t: out_payload expected %0h actual %0h",
					$realtime, exp_r.payload, got.payload);
				errors++;
			end
			if (got.prio !== exp_r.prio) begin
				$display("%0t: out_priority expected %0d actual %0d",
					$realtime, exp_r.prio, got.prio);
				errors++;
			end
			if (got.occ !== exp_r.occ) begin
				$display("%0t: occupancy expected %0d actual %0d",
					$realtime, exp_r.occ, got.occ);
				errors++;
			end
			if (word[M_TDATA_W-1:$bits(res_t)] !== '0) begin
				$display("%0t: fill bits expected 0 actual %0h",
					$realtime, word[M_TDATA_W-1:$bits(res_t)]);
				errors++;
			end
		endfunction
	endclass

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata  = '0;
	logic [S_TUSER_W-1:0] s_tuser  = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;

	pq_mirror sb = new();

	bit steady    = 1'b0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	int results_seen = 0;
	int quiet_cycles = 0;

	stable_priority_queue_core #(
		.DEPTH       (QDEPTH),
		.PAYLOAD_BITS(EXT_PAY_W)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always #5 clk = ~clk;

	// Offer one item, with random idle cycles first, and note it once taken
	task automatic send_item(input logic mode, input logic [PRIO_W-1:0] prio,
			input logic [EXT_PAY_W-1:0] pay);
		while (!steady && $urandom_range(0, 99) < 35) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {{(S_TDATA_W - PRIO_W - EXT_PAY_W){1'b0}}, pay, prio};
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_request(mode, prio, pay);
	endtask

	// Mostly legal levels, now and then the unused codes 0, 6 and 7
	function automatic logic [PRIO_W-1:0] pick_prio();
		if ($urandom_range(0, 99) < 10)
			return PRIO_W'($urandom_range(0, 7));
		return PRIO_W'($urandom_range(1, 5));
	endfunction

	function automatic logic [EXT_PAY_W-1:0] pick_payload();
		case ($urandom_range(0, 15))
			0:       return '0;
			1:       return '1;
			default: return EXT_PAY_W'($urandom);
		endcase
	endfunction

	// Receiver: check result items, random back-pressure, one long hold-off
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			sb.check_response(m_tdata);
			results_seen <= results_seen + 1;
		end
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else if (!hold_done && results_seen == HOLD_AT) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_LEN;
			m_tready  <= 1'b0;
		end else begin
			m_tready <= steady || ($urandom_range(0, 99) >= 35);
		end
	end

	// Watchdog on cycles with no item moving on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_MAX) begin
			$display("%0t: no item moved for %0d cycles", $realtime, quiet_cycles);
			$display("stable_priority_queue_core verification failed");
			$finish;
		end
	end

	initial begin
		int insert_bias;
		logic mode;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: remove on empty, every priority code, field extremes
		send_item(OP_REMOVE, 3'd0, '0);
		send_item(OP_INSERT, 3'd0, 32'h0000_0000);
		send_item(OP_INSERT, 3'd1, 32'hFFFF_FFFF);
		send_item(OP_INSERT, 3'd2, 32'hAAAA_AAAA);
		send_item(OP_INSERT, 3'd3, 32'h5555_5555);
		send_item(OP_INSERT, 3'd4, 32'h0000_0001);
		send_item(OP_INSERT, 3'd5, 32'h8000_0000);
		send_item(OP_INSERT, 3'd6, 32'h1234_5678);
		send_item(OP_INSERT, 3'd7, 32'hFEDC_BA98);
		// equal priorities to exercise the arrival-order tie break, up to full
		for (int i = 0; i < 8; i++)
			send_item(OP_INSERT, 3'd3, 32'hC0DE_0000 + i);
		// insert into a full queue is rejected
		send_item(OP_INSERT, 3'd7, 32'hFFFF_FFFF);
		for (int i = 0; i < 6; i++)
			send_item(OP_REMOVE, 3'd7, 32'hFFFF_FFFF);

		// Random: segments with differing insert bias to sweep fill levels
		for (int i = 0; i < RAND_ITEMS; i++) begin
			if (i % SEG_LEN == 0) begin
				case ($urandom_range(0, 3))
					0:       insert_bias = 85;
					1:       insert_bias = 20;
					default: insert_bias = 50;
				endcase
				steady <= (i / SEG_LEN == 6);
			end
			mode = ($urandom_range(0, 99) < insert_bias) ? OP_INSERT : OP_REMOVE;
			send_item(mode, pick_prio(), pick_payload());
		end
		s_tvalid <= 1'b0;
		steady   <= 1'b0;

		// Drain, then let the block settle
		while (sb.expected_results.size() > 0)
			@(posedge clk);
		repeat (TAIL_WAIT) @(posedge clk);

		if (sb.errors == 0 && sb.expected_results.size() == 0)
			$display("stable_priority_queue_core verification clean");
		else
			$display("stable_priority_queue_core verification failed");
		$finish;
	end

endmodule
